// ----- rtl/core/b2mb_pkg.sv -----
// types and constants of the bmp 32 bpp to mono bitmap unit
// parser phases, result kinds, parser context and output queue entry
// no dependencies
package b2mb_pkg;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXELS,
		PH_IDLE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_DONE,
		KIND_BAD_MAGIC,
		KIND_BAD_FORMAT
	} kind_t;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_LEVEL  = 1'b0;
	localparam cfg_idx_t CFG_BUFFER = 1'b1;

	localparam logic [8:0] LEVEL_RESET = 9'd128;

	// header byte positions where a field completes
	localparam logic [31:0] POS_MAGIC  = 32'd1;
	localparam logic [31:0] POS_OFFSET = 32'd13;
	localparam logic [31:0] POS_WIDTH  = 32'd21;
	localparam logic [31:0] POS_HEIGHT = 32'd25;
	localparam logic [31:0] POS_PLANES = 32'd27;
	localparam logic [31:0] POS_BPP    = 32'd29;
	localparam logic [31:0] POS_COMPR  = 32'd33;

	localparam logic [15:0] BMP_MAGIC  = 16'h4D42;
	localparam logic [15:0] BMP_PLANES = 16'd1;
	localparam logic [15:0] BMP_BPP    = 16'd32;
	localparam logic [31:0] MIN_OFFSET = 32'd34;

	// output queue
	localparam int OUT_DEPTH = 8;
	localparam int OUT_AW    = 3;
	localparam int OUT_CW    = 4;

	typedef struct packed {
		logic [31:0] pos;
		logic [31:0] fa;
		logic [31:0] offset;
		logic [15:0] width;
		logic [15:0] height;
		logic        fmt_ok;
		logic [15:0] row;
		logic [15:0] col;
		logic [1:0]  chan;
		logic [23:0] bgr;
		logic [7:0]  pack;
		logic [31:0] row_base;
	} ctx_t;

	typedef struct packed {
		kind_t       kind;
		logic [23:0] addr;
		logic [7:0]  data;
	} result_t;

endpackage

// ----- rtl/core/bmp32_to_mono_bitmap_unit.sv -----
// flow: a transferred byte is registered, parsed, and its results are queued for the master side
// throughput: one file byte per cycle while s_tready is high; each byte passes one input
// register and one combinational parse step, results wait in an 8-entry queue (up to 2
// results per byte); the slave side stalls only while 5 or more results are queued
// reset: arst_n clears parser, queue and registers (level 128, capacity 0) at once
// bmp 32 bpp stream parser and threshold packer to a 1 bpp bitmap
// depends on b2mb_pkg
module bmp32_to_mono_bitmap_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  b2mb_pkg::cfg_idx_t   cfg_index,
	input  logic [23:0]          cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] file_byte
	input  logic                 s_tuser,   // [0] start_req
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,   // [23:0] byte_address, [31:24] bitmap_byte
	output logic [1:0]           m_tuser    // [1:0] kind
);
	import b2mb_pkg::*;

	localparam logic [OUT_CW-1:0] READY_MAX = OUT_CW'(OUT_DEPTH - 4);
	localparam logic [OUT_CW-1:0] S1_MAX    = OUT_CW'(OUT_DEPTH - 2);
	localparam logic [OUT_CW-1:0] DEPTH_C   = OUT_CW'(OUT_DEPTH);

	logic [8:0]  level_q;
	logic [23:0] buf_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	phase_t phase_q, phase_d, ph_c;
	ctx_t   ctx_q, ctx_d, cur;

	result_t res0, res1;
	logic [1:0] push_n;

	result_t           mem [OUT_DEPTH];
	logic [OUT_AW-1:0] head_q, tail_q;
	logic [OUT_CW-1:0] cnt_q;
	logic              pop;

	// decode signals
	logic [31:0] fa_n, mag, pix_addr;
	logic [7:0]  bl, gr, rd, mx, mn, pack_n;
	logic        dark, row_end, last_px, byte_end, in_range;
	logic        magic_bad, fmt_ok_end, empty;
	logic [16:0] col_p1, row_p1;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RESET;
			buf_q   <= 24'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEVEL:  level_q <= cfg_data[8:0];
				CFG_BUFFER: buf_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = (cnt_q <= READY_MAX);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// a start byte sees the parser as freshly cleared
	always_comb begin
		cur  = start_s1 ? '0 : ctx_q;
		ph_c = start_s1 ? PH_HEADER : phase_q;
		fa_n = {byte_s1, cur.fa[31:8]};
		mag  = fa_n[31] ? (~fa_n + 32'd1) : fa_n;

		bl = cur.bgr[7:0];
		gr = cur.bgr[15:8];
		rd = cur.bgr[23:16];
		mx = rd;
		mn = rd;
		if (gr > mx) mx = gr;
		if (bl > mx) mx = bl;
		if (gr < mn) mn = gr;
		if (bl < mn) mn = bl;
		dark = ({1'b0, mx} + {1'b0, mn}) < {level_q, 1'b0};

		col_p1   = {1'b0, cur.col} + 17'd1;
		row_p1   = {1'b0, cur.row} + 17'd1;
		row_end  = (col_p1 == {1'b0, cur.width});
		last_px  = row_end && (row_p1 == {1'b0, cur.height});
		byte_end = (cur.col[2:0] == 3'd7) || row_end;
		pix_addr = cur.row_base + 32'(cur.col[15:3]);
		in_range = pix_addr < {8'd0, buf_q};
		pack_n   = cur.pack | (dark ? (8'h80 >> cur.col[2:0]) : 8'h00);

		magic_bad  = (fa_n[31:16] != BMP_MAGIC);
		fmt_ok_end = cur.fmt_ok && (fa_n == 32'd0);
		empty      = (cur.width == 16'd0) || (cur.height == 16'd0);
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (valid_s1) begin
			phase_d = ph_c;
			unique case (ph_c)
				PH_HEADER: begin
					priority if (cur.pos == POS_MAGIC && magic_bad) begin
						phase_d = PH_IDLE;
					end else if (cur.pos == POS_COMPR) begin
						priority if (!fmt_ok_end || empty) phase_d = PH_IDLE;
						else if (cur.offset == MIN_OFFSET) phase_d = PH_PIXELS;
						else phase_d = PH_SKIP;
					end else begin
						phase_d = PH_HEADER;
					end
				end
				PH_SKIP: begin
					if (cur.pos + 32'd1 == cur.offset) phase_d = PH_PIXELS;
				end
				PH_PIXELS: begin
					if (cur.chan == 2'd3 && last_px) phase_d = PH_IDLE;
				end
				PH_IDLE: ;
				default: ;
			endcase
		end
	end

	// context update and results
	always_comb begin
		ctx_d  = ctx_q;
		push_n = 2'd0;
		res0   = '0;
		res1   = '0;
		if (valid_s1) begin
			ctx_d = cur;
			unique case (ph_c)
				PH_HEADER: begin
					ctx_d.fa  = fa_n;
					ctx_d.pos = cur.pos + 32'd1;
					priority if (cur.pos == POS_MAGIC) begin
						if (magic_bad) begin
							res0.kind = KIND_BAD_MAGIC;
							push_n    = 2'd1;
						end else begin
							ctx_d.fmt_ok = 1'b1;
						end
					end else if (cur.pos == POS_OFFSET) begin
						ctx_d.offset = fa_n;
						if (fa_n < MIN_OFFSET) ctx_d.fmt_ok = 1'b0;
					end else if (cur.pos == POS_WIDTH || cur.pos == POS_HEIGHT) begin
						if (mag[31:16] != 16'd0) ctx_d.fmt_ok = 1'b0;
						if (cur.pos == POS_WIDTH) ctx_d.width = mag[15:0];
						else ctx_d.height = mag[15:0];
					end else if (cur.pos == POS_PLANES) begin
						if (fa_n[31:16] != BMP_PLANES) ctx_d.fmt_ok = 1'b0;
					end else if (cur.pos == POS_BPP) begin
						if (fa_n[31:16] != BMP_BPP) ctx_d.fmt_ok = 1'b0;
					end else if (cur.pos == POS_COMPR) begin
						ctx_d.fmt_ok = fmt_ok_end;
						priority if (!fmt_ok_end) begin
							res0.kind = KIND_BAD_FORMAT;
							push_n    = 2'd1;
						end else if (empty) begin
							res0.kind = KIND_DONE;
							push_n    = 2'd1;
						end else begin
							push_n = 2'd0;
						end
					end else begin
						push_n = 2'd0;
					end
				end
				PH_SKIP: begin
					ctx_d.pos = cur.pos + 32'd1;
				end
				PH_PIXELS: begin
					ctx_d.chan = cur.chan + 2'd1;
					unique case (cur.chan)
						2'd0: ctx_d.bgr = {16'd0, byte_s1};
						2'd1: ctx_d.bgr[15:8] = byte_s1;
						2'd2: ctx_d.bgr[23:16] = byte_s1;
						2'd3: begin
							ctx_d.pack = pack_n;
							if (byte_end) begin
								ctx_d.pack = 8'd0;
								if (in_range) begin
									res0.kind = KIND_BYTE;
									res0.addr = pix_addr[23:0];
									res0.data = pack_n;
									push_n    = 2'd1;
								end
							end
							if (row_end) begin
								ctx_d.col      = 16'd0;
								ctx_d.row      = row_p1[15:0];
								ctx_d.row_base = cur.row_base
									+ 32'(({1'b0, cur.width} + 17'd7) >> 3);
							end else begin
								ctx_d.col = col_p1[15:0];
							end
							// done follows the last bitmap byte in the same step
							if (last_px) begin
								if (byte_end && in_range) begin
									res1.kind = KIND_DONE;
									push_n    = 2'd2;
								end else begin
									res0.kind = KIND_DONE;
									push_n    = 2'd1;
								end
							end
						end
						default: ;
					endcase
				end
				PH_IDLE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			ctx_q   <= '0;
		end else begin
			phase_q <= phase_d;
			ctx_q   <= ctx_d;
		end
	end

	// result queue
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {mem[head_q].data, mem[head_q].addr};
	assign m_tuser  = mem[head_q].kind;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem[tail_q] <= res0;
		if (push_n == 2'd2) mem[tail_q + OUT_AW'(1)] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			tail_q <= tail_q + OUT_AW'(push_n);
			if (pop) head_q <= head_q + OUT_AW'(1);
			cnt_q <= cnt_q + OUT_CW'(push_n) - OUT_CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("result queue overflow");

	a_room_for_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> cnt_q <= S1_MAX)
		else $error("no room for results of staged byte");

	a_idle_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE && !(valid_s1 && start_s1)) |=> phase_q == PH_IDLE)
		else $error("parser left idle without start");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PIXELS |-> ctx_q.col < ctx_q.width)
		else $error("column beyond image width");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != KIND_BYTE) |-> m_tdata == 32'd0)
		else $error("status result with nonzero payload");
`endif

endmodule
